// ===== design/rtnp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rtnp_pkg;
    localparam int CharW = 8;
    localparam int DurW = 16;
    localparam int OctW = 4;
    localparam int NoteW = 8;
    localparam int LenW = 32;
    localparam int NumMax = 65535;
    localparam logic [DurW-1:0] CapReset = 16'd180;
    localparam logic [DurW-1:0] TempoReset = 16'd63;
    localparam int FifoDepthDefault = 4;

    localparam logic [0:0] RegDurationCap = 1'b0;
    localparam logic [0:0] RegOctaveOffset = 1'b1;

    localparam logic [3:0] PhColon = 4'd0;
    localparam logic [3:0] PhHdrD = 4'd1;
    localparam logic [3:0] PhDSkip = 4'd2;
    localparam logic [3:0] PhDNum = 4'd3;
    localparam logic [3:0] PhHdrO = 4'd4;
    localparam logic [3:0] PhOSkip = 4'd5;
    localparam logic [3:0] PhODigit = 4'd6;
    localparam logic [3:0] PhOSep = 4'd7;
    localparam logic [3:0] PhHdrB = 4'd8;
    localparam logic [3:0] PhBSkip = 4'd9;
    localparam logic [3:0] PhBNum = 4'd10;
    localparam logic [3:0] PhNoteLen = 4'd11;
    localparam logic [3:0] PhNoteShp = 4'd12;
    localparam logic [3:0] PhNoteDot = 4'd13;
    localparam logic [3:0] PhNoteOct = 4'd14;
    localparam logic [3:0] PhNoteSep = 4'd15;

    // Command from the parser to the arithmetic back end.
    localparam logic [1:0] CmdTempo = 2'd0;
    localparam logic [1:0] CmdNote = 2'd1;
    localparam logic [1:0] CmdEmit = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [DurW-1:0] divisor;
        logic [3:0] semitone;
        logic is_rest;
        logic [OctW-1:0] octave;
        logic dotted;
        logic song_end;
    } cmd_t;

    typedef struct packed {
        logic is_rest;
        logic [NoteW-1:0] note_number;
        logic [DurW-1:0] duration_ms;
        logic song_end;
    } result_t;
endpackage
`default_nettype wire

// ===== design/rtnp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rtnp_char_if;
    logic valid;
    logic ready;
    logic [7:0] text_char;
    modport source (output valid, output text_char, input ready);
    modport sink (input valid, input text_char, output ready);
endinterface

interface rtnp_res_if;
    logic valid;
    logic ready;
    logic is_rest;
    logic [7:0] note_number;
    logic [15:0] duration_ms;
    logic song_end;
    modport source (output valid, output is_rest, output note_number,
                    output duration_ms, output song_end, input ready);
    modport sink (input valid, input is_rest, input note_number,
                  input duration_ms, input song_end, output ready);
endinterface

interface rtnp_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ringtone_text_note_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Ringtone text parser: one character is taken per word on text_in and a
// note result word appears on note_out. A character that both closes a
// note and opens the next one, or that ends a header without tempo and
// opens a note, makes two commands and holds the input off until the
// second is queued. A note letter or tempo field starts a 32-step
// shift-subtract division in the back end, and a queue of Depth commands
// lets characters keep flowing meanwhile. Configuration words on cfg set
// the duration cap (index 0) and the octave shift (index 1) and are
// always taken.
// No clearing pass after reset.
module ringtone_text_note_parser_unit #(
    parameter int Depth = rtnp_pkg::FifoDepthDefault
) (
    input wire logic clk,
    input wire logic rst_n,
    rtnp_char_if.sink text_in,
    rtnp_res_if.source note_out,
    rtnp_cfg_if.sink cfg
);
    logic [15:0] cap_reg;
    logic [3:0] ofs_reg;
    logic q_full, q_push, q_pop, q_empty;
    rtnp_pkg::cmd_t push_cmd, pop_cmd;
    rtnp_pkg::result_t res;
    logic rv;

    // Configuration is accepted every cycle.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= rtnp_pkg::CapReset;
            ofs_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == rtnp_pkg::RegDurationCap)
                cap_reg <= cfg.data;
            else
                ofs_reg <= cfg.data[3:0];
        end
    end

    rtnp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(text_in.valid), .in_ready(text_in.ready),
        .in_char(text_in.text_char),
        .q_full(q_full), .q_push(q_push), .q_cmd(push_cmd)
    );

    rtnp_fifo #(.Depth(Depth)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(push_cmd), .full(q_full),
        .pop(q_pop), .pop_data(pop_cmd), .empty(q_empty)
    );

    rtnp_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_cmd(pop_cmd), .q_pop(q_pop),
        .duration_cap(cap_reg), .oct_shift(ofs_reg),
        .res_valid(rv), .res_ready(note_out.ready), .res(res)
    );

    assign note_out.valid = rv;
    assign note_out.is_rest = res.is_rest;
    assign note_out.note_number = res.note_number;
    assign note_out.duration_ms = res.duration_ms;
    assign note_out.song_end = res.song_end;
endmodule
`default_nettype wire

// ===== design/rtnp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Character parser. Every character is handled in the cycle it is taken. A
// character that closes one note and opens the next, or ends a bare header
// and opens a note, yields two commands; the second is held in a register
// and pushed once the queue has room, while the input is held off.
module rtnp_front (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [7:0] in_char,
    input wire logic q_full,
    output logic q_push,
    output rtnp_pkg::cmd_t q_cmd
);
    logic [3:0] phase_reg, phase_next;
    logic [15:0] num_reg, num_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [3:0] doct_reg, doct_next;
    logic hold_reg, hold_next;
    rtnp_pkg::cmd_t hold_cmd_reg, hold_cmd_next;
    logic pa_push, pb_push;
    rtnp_pkg::cmd_t pa_cmd, pb_cmd;
    logic sep_done;
    logic is_dig;
    logic [19:0] acc_wide;
    logic [15:0] acc_sat;
    logic [15:0] div_sel;
    logic [3:0] semi;
    logic [3:0] ph;
    logic go;
    logic pend_note;

    assign in_ready = !q_full && !hold_reg;
    assign go = in_valid && in_ready;
    assign is_dig = in_char >= 8'd48 && in_char <= 8'd57;
    assign acc_wide = {num_reg, 3'b000} + {2'b00, num_reg, 1'b0}
                      + {16'd0, in_char[3:0]};
    assign acc_sat = (acc_wide > 20'(rtnp_pkg::NumMax)) ? 16'hFFFF : acc_wide[15:0];

    always_comb
    begin
        case (in_char)
            8'h63: semi = 4'd1;
            8'h64: semi = 4'd3;
            8'h65: semi = 4'd5;
            8'h66: semi = 4'd6;
            8'h67: semi = 4'd8;
            8'h61: semi = 4'd10;
            8'h62: semi = 4'd12;
            default: semi = 4'd0;
        endcase
    end

    assign div_sel = (num_reg != 16'd0) ? num_reg :
                     ((dlen_reg != 16'd0) ? dlen_reg : 16'd1);

    // The parser has fall-through phases; they are resolved by walking the
    // phase forward within the same cycle (each step is narrow).
    always_comb
    begin
        phase_next = phase_reg;
        num_next = num_reg;
        dlen_next = dlen_reg;
        doct_next = doct_reg;
        hold_next = hold_reg;
        hold_cmd_next = hold_cmd_reg;
        q_push = 1'b0;
        q_cmd = '0;
        pa_push = 1'b0;
        pa_cmd = '0;
        pb_push = 1'b0;
        pb_cmd = '0;
        sep_done = 1'b0;
        ph = phase_reg;
        pend_note = phase_reg >= rtnp_pkg::PhNoteShp;
        if (go)
        begin
            if (in_char == 8'd0)
            begin
                if (pend_note)
                begin
                    pa_push = 1'b1;
                    pa_cmd.cmd = rtnp_pkg::CmdEmit;
                    pa_cmd.song_end = 1'b1;
                end
                phase_next = rtnp_pkg::PhColon;
                num_next = '0;
                dlen_next = 16'd4;
                doct_next = 4'd6;
            end
            else
            begin
                if (ph == rtnp_pkg::PhHdrD && in_char != 8'h64)
                    ph = rtnp_pkg::PhHdrO;
                if (ph == rtnp_pkg::PhHdrO && in_char != 8'h6F)
                    ph = rtnp_pkg::PhHdrB;
                if (ph == rtnp_pkg::PhHdrB && in_char != 8'h62)
                begin
                    // Without a tempo field the default tempo is used.
                    pa_push = 1'b1;
                    pa_cmd.cmd = rtnp_pkg::CmdTempo;
                    pa_cmd.divisor = rtnp_pkg::TempoReset;
                    num_next = '0;
                    ph = rtnp_pkg::PhNoteLen;
                end
                if (ph == rtnp_pkg::PhNoteShp && in_char != 8'h23)
                    ph = rtnp_pkg::PhNoteDot;
                if (ph == rtnp_pkg::PhNoteDot && in_char != 8'h2E)
                    ph = rtnp_pkg::PhNoteOct;
                if (ph == rtnp_pkg::PhNoteOct && !is_dig)
                    ph = rtnp_pkg::PhNoteSep;
                if (ph == rtnp_pkg::PhNoteSep)
                begin
                    pa_push = 1'b1;
                    pa_cmd.cmd = rtnp_pkg::CmdEmit;
                    num_next = '0;
                    ph = rtnp_pkg::PhNoteLen;
                    // A comma is used up by the separator itself.
                    sep_done = in_char == 8'h2C;
                end
                phase_next = ph;
                if (!sep_done)
                begin
                    case (ph)
                        rtnp_pkg::PhColon:
                            if (in_char == 8'h3A)
                                phase_next = rtnp_pkg::PhHdrD;
                        rtnp_pkg::PhHdrD: phase_next = rtnp_pkg::PhDSkip;
                        rtnp_pkg::PhDSkip:
                        begin
                            num_next = '0;
                            phase_next = rtnp_pkg::PhDNum;
                        end
                        rtnp_pkg::PhDNum:
                            if (is_dig)
                                num_next = acc_sat;
                            else
                            begin
                                if (num_reg != 16'd0)
                                    dlen_next = num_reg;
                                phase_next = rtnp_pkg::PhHdrO;
                            end
                        rtnp_pkg::PhHdrO: phase_next = rtnp_pkg::PhOSkip;
                        rtnp_pkg::PhOSkip: phase_next = rtnp_pkg::PhODigit;
                        rtnp_pkg::PhODigit:
                        begin
                            if (in_char >= 8'd51 && in_char <= 8'd55)
                                doct_next = in_char[3:0];
                            phase_next = rtnp_pkg::PhOSep;
                        end
                        rtnp_pkg::PhOSep: phase_next = rtnp_pkg::PhHdrB;
                        rtnp_pkg::PhHdrB: phase_next = rtnp_pkg::PhBSkip;
                        rtnp_pkg::PhBSkip:
                        begin
                            num_next = '0;
                            phase_next = rtnp_pkg::PhBNum;
                        end
                        rtnp_pkg::PhBNum:
                            if (is_dig)
                                num_next = acc_sat;
                            else
                            begin
                                pb_push = 1'b1;
                                pb_cmd.cmd = rtnp_pkg::CmdTempo;
                                pb_cmd.divisor = num_reg;
                                num_next = '0;
                                phase_next = rtnp_pkg::PhNoteLen;
                            end
                        rtnp_pkg::PhNoteLen:
                            if (is_dig)
                                num_next = (phase_reg == rtnp_pkg::PhNoteLen) ? acc_sat
                                           : {12'd0, in_char[3:0]};
                            else
                            begin
                                // Coming from another phase, the length
                                // number is still empty.
                                pb_push = 1'b1;
                                pb_cmd.cmd = rtnp_pkg::CmdNote;
                                pb_cmd.divisor = (phase_reg == rtnp_pkg::PhNoteLen) ? div_sel
                                                 : ((dlen_reg != 16'd0) ? dlen_reg : 16'd1);
                                pb_cmd.semitone = semi;
                                pb_cmd.is_rest = semi == 4'd0;
                                pb_cmd.octave = doct_reg;
                                num_next = '0;
                                phase_next = rtnp_pkg::PhNoteShp;
                            end
                        rtnp_pkg::PhNoteShp:
                        begin
                            pb_push = 1'b1;
                            pb_cmd.cmd = rtnp_pkg::CmdNote;
                            pb_cmd.divisor = 16'd0;
                            pb_cmd.semitone = 4'd1;
                            phase_next = rtnp_pkg::PhNoteDot;
                        end
                        rtnp_pkg::PhNoteDot:
                        begin
                            pb_push = 1'b1;
                            pb_cmd.cmd = rtnp_pkg::CmdNote;
                            pb_cmd.divisor = 16'd0;
                            pb_cmd.dotted = 1'b1;
                            phase_next = rtnp_pkg::PhNoteOct;
                        end
                        rtnp_pkg::PhNoteOct:
                        begin
                            pb_push = 1'b1;
                            pb_cmd.cmd = rtnp_pkg::CmdNote;
                            pb_cmd.divisor = 16'd0;
                            pb_cmd.song_end = 1'b1;
                            pb_cmd.octave = in_char[3:0];
                            phase_next = rtnp_pkg::PhNoteSep;
                        end
                        default: phase_next = ph;
                    endcase
                end
            end
        end

        // The first command goes to the queue now; a second one waits in
        // the hold register for the next free slot.
        if (hold_reg)
        begin
            q_push = !q_full;
            q_cmd = hold_cmd_reg;
            if (!q_full)
                hold_next = 1'b0;
        end
        else if (pa_push)
        begin
            q_push = 1'b1;
            q_cmd = pa_cmd;
            if (pb_push)
            begin
                hold_next = 1'b1;
                hold_cmd_next = pb_cmd;
            end
        end
        else
        begin
            q_push = pb_push;
            q_cmd = pb_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rtnp_pkg::PhColon;
            num_reg <= '0;
            dlen_reg <= 16'd4;
            doct_reg <= 4'd6;
            hold_reg <= 1'b0;
            hold_cmd_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            num_reg <= num_next;
            dlen_reg <= dlen_next;
            doct_reg <= doct_next;
            hold_reg <= hold_next;
            hold_cmd_reg <= hold_cmd_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && in_char == 8'd0) |=> phase_reg == rtnp_pkg::PhColon)
        else $error("end of song did not restart parsing");
    assert property (@(posedge clk) disable iff (!rst_n)
        (dlen_reg != 16'd0))
        else $error("default length became zero");
endmodule
`default_nettype wire

// ===== design/rtnp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rtnp_fifo #(
    parameter int Depth = rtnp_pkg::FifoDepthDefault
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire rtnp_pkg::cmd_t push_data,
    output logic full,
    input wire logic pop,
    output rtnp_pkg::cmd_t pop_data,
    output logic empty
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    rtnp_pkg::cmd_t mem [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0] cnt_reg;

    assign full = cnt_reg == (AW+1)'(Depth);
    assign empty = cnt_reg == '0;
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(Depth))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance");
endmodule
`default_nettype wire

// ===== design/rtnp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic back end: a shared 32 by 16 restoring divider, one quotient
// bit per cycle, forms the whole-note length and each note length.
module rtnp_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic q_empty,
    input wire rtnp_pkg::cmd_t q_cmd,
    output logic q_pop,
    input wire logic [15:0] duration_cap,
    input wire logic [3:0] oct_shift,
    output logic res_valid,
    input wire logic res_ready,
    output rtnp_pkg::result_t res
);
    localparam logic [1:0] SIdle = 2'd0;
    localparam logic [1:0] SDiv = 2'd1;
    localparam logic [1:0] SOut = 2'd2;

    logic [1:0] st_reg, st_next;
    logic [31:0] whole_reg;
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [4:0] bit_reg;
    logic div_tempo_reg;
    logic [31:0] plen_reg;
    logic [3:0] psemi_reg;
    logic prest_reg;
    logic [3:0] poct_reg;
    logic [17:0] trial;
    logic [16:0] rem_sh;
    logic [31:0] dur32;
    logic [7:0] oct8;
    logic [7:0] nn;
    rtnp_pkg::cmd_t c;

    assign c = q_cmd;
    assign rem_sh = {rem_reg[15:0], quo_reg[31]};
    assign trial = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign q_pop = (st_reg == SIdle) && !q_empty;

    assign dur32 = {1'b0, plen_reg[31:1]};
    assign oct8 = {4'd0, poct_reg} + {4'd0, oct_shift};
    assign nn = ({oct8[4:0], 3'b000} + {oct8[5:0], 2'b00}) + {4'd0, psemi_reg} - 8'd48;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= SIdle;
            whole_reg <= '0;
            bit_reg <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            case (st_reg)
                SIdle:
                    if (!q_empty)
                    begin
                        case (c.cmd)
                            rtnp_pkg::CmdTempo:
                            begin
                                // A tempo of zero is played as one beat per minute.
                                quo_reg <= 32'd60000;
                                rem_reg <= '0;
                                dvs_reg <= (c.divisor != 16'd0) ? c.divisor : 16'd1;
                                div_tempo_reg <= 1'b1;
                                bit_reg <= '0;
                                st_reg <= SDiv;
                            end
                            rtnp_pkg::CmdNote:
                                if (c.divisor != 16'd0)
                                begin
                                    quo_reg <= whole_reg;
                                    rem_reg <= '0;
                                    dvs_reg <= c.divisor;
                                    div_tempo_reg <= 1'b0;
                                    bit_reg <= '0;
                                    psemi_reg <= c.semitone;
                                    prest_reg <= c.is_rest;
                                    poct_reg <= c.octave;
                                    st_reg <= SDiv;
                                end
                                else if (c.dotted)
                                    plen_reg <= plen_reg + {1'b0, plen_reg[31:1]};
                                else if (c.song_end)
                                    poct_reg <= c.octave;
                                else if (!prest_reg)
                                    psemi_reg <= psemi_reg + 4'd1;
                            default:
                            begin
                                res.is_rest <= prest_reg;
                                res.note_number <= prest_reg ? 8'd0 : nn;
                                res.duration_ms <= (dur32 > {16'd0, duration_cap})
                                                   ? duration_cap : dur32[15:0];
                                res.song_end <= c.song_end;
                                res_valid <= 1'b1;
                                st_reg <= SOut;
                            end
                        endcase
                    end
                SDiv:
                begin
                    if (trial[17])
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= trial[16:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd31)
                    begin
                        st_reg <= SIdle;
                        if (div_tempo_reg)
                            whole_reg <= {quo_reg[28:0], !trial[17], 2'b00};
                        else
                            plen_reg <= {quo_reg[30:0], !trial[17]};
                    end
                end
                default:
                    if (res_ready)
                    begin
                        res_valid <= 1'b0;
                        st_reg <= SIdle;
                    end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> st_reg == SOut)
        else $error("result shown outside output state");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == SDiv) |-> dvs_reg != 16'd0)
        else $error("division by zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == SIdle)
        else $error("command taken while busy");
endmodule
`default_nettype wire
